FILE: rtl/core/sha1s_pkg.sv
`timescale 1ns / 1ps

package sha1s_pkg;

   // input item kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_LAST = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // round constants
   localparam logic [31:0] K_0 = 32'h5A827999;
   localparam logic [31:0] K_1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_3 = 32'hCA62C1D6;

   // initial hash values
   localparam logic [31:0] H_INIT [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam int         ROUNDS     = 80;
   localparam int         DIGEST_WDS = 5;

   // controller to datapath
   typedef struct packed {
      logic       absorb;     // message byte from the request port
      logic       pad;        // padding byte
      logic       pad_first;  // padding byte is the 0x80 marker
      logic       round;      // one compression round
      logic       fold;       // add working vars into the hash words
      logic       clear;      // back to initial state after a digest
      logic [6:0] round_idx;
      logic [2:0] out_index;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic block_full;  // next byte written completes the block
      logic final_blk;   // current padding block carries the length
   } status_type;

endpackage

FILE: rtl/core/sha1s_ctrl.sv
`timescale 1ns / 1ps

module sha1s_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_kind,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_word_index,
   output logic                  rsp_last_word,
   input  sha1s_pkg::status_type status,
   output sha1s_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_COMP = 3'd1;
   localparam logic [2:0] ST_FOLD = 3'd2;
   localparam logic [2:0] ST_PAD  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   localparam logic [6:0] LAST_ROUND = 7'(sha1s_pkg::ROUNDS - 1);
   localparam logic [2:0] LAST_IDX   = 3'(sha1s_pkg::DIGEST_WDS - 1);

   logic [2:0] state_ff, state_in;
   logic [2:0] after_ff, after_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] idx_ff, idx_in;
   logic       first_ff, first_in;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      after_in      = after_ff;
      round_in      = round_ff;
      idx_in        = idx_ff;
      first_in      = first_ff;
      cmd           = '0;
      cmd.round_idx = round_ff;
      cmd.out_index = idx_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_kind)
                  sha1s_pkg::KIND_DATA, sha1s_pkg::KIND_LAST: begin
                     cmd.absorb = 1'b1;
                     if (req_kind == sha1s_pkg::KIND_LAST) begin
                        first_in = 1'b1;
                     end
                     if (status.block_full) begin
                        state_in = ST_COMP;
                        round_in = '0;
                        after_in = (req_kind == sha1s_pkg::KIND_LAST) ? ST_PAD : ST_IDLE;
                     end else if (req_kind == sha1s_pkg::KIND_LAST) begin
                        state_in = ST_PAD;
                     end
                  end
                  sha1s_pkg::KIND_END: begin
                     first_in = 1'b1;
                     state_in = ST_PAD;
                  end
                  default: ;  // undefined kind: dropped
               endcase
            end
         end
         ST_COMP: begin
            cmd.round = 1'b1;
            round_in  = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            idx_in   = '0;
            state_in = after_ff;
         end
         ST_PAD: begin
            cmd.pad       = 1'b1;
            cmd.pad_first = first_ff;
            first_in      = 1'b0;
            if (status.block_full) begin
               state_in = ST_COMP;
               round_in = '0;
               after_in = status.final_blk ? ST_OUT : ST_PAD;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == LAST_IDX) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == LAST_IDX);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         after_ff <= ST_IDLE;
         round_ff <= '0;
         idx_ff   <= '0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         first_ff <= first_in;
      end
   end

endmodule

FILE: rtl/core/sha1s_dp.sv
`timescale 1ns / 1ps

module sha1s_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  sha1s_pkg::cmd_type    cmd,
   input  logic [7:0]            req_data_byte,
   output sha1s_pkg::status_type status,
   output logic [31:0]           digest_word
);

   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [63:0] bit_cnt_ff, bit_cnt_in;
   logic [5:0]  fill_ff, fill_in;
   logic        len_ok_ff, len_ok_in;
   logic [23:0] word_ff;
   logic [31:0] sched_ff [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;

   logic        wr_byte;
   logic [7:0]  byte_val;
   logic [7:0]  len_byte;
   logic [31:0] f_val, k_val, t_val, w_new;

   assign wr_byte = cmd.absorb | cmd.pad;

   // length byte for fill positions 56..63, most significant first
   assign len_byte = bit_cnt_ff[{~fill_ff[2:0], 3'b000} +: 8];

   // byte entering the block
   always_comb begin
      if (cmd.absorb) begin
         byte_val = req_data_byte;
      end else if (cmd.pad_first) begin
         byte_val = sha1s_pkg::PAD_BYTE;
      end else if (len_ok_ff && (fill_ff[5:3] == 3'b111)) begin
         byte_val = len_byte;
      end else begin
         byte_val = 8'h00;
      end
   end

   // the length flag is set only while padding; a marker at position 63 never carries it
   assign status.block_full = (fill_ff == 6'd63);
   assign status.final_blk  = len_ok_ff;

   // round function and constant by round group
   always_comb begin
      if (cmd.round_idx < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = sha1s_pkg::K_0;
      end else if (cmd.round_idx < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1s_pkg::K_1;
      end else if (cmd.round_idx < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = sha1s_pkg::K_2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1s_pkg::K_3;
      end
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + sched_ff[0];

   // message schedule expansion from the sliding 16-word window
   always_comb begin
      logic [31:0] x;
      x     = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      w_new = {x[30:0], x[31]};
   end

   // control-side state: hash words, counters
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         h_in[i] = h_ff[i];
      end
      bit_cnt_in = bit_cnt_ff;
      fill_in    = fill_ff;
      len_ok_in  = len_ok_ff;
      if (cmd.fold) begin
         h_in[0] = h_ff[0] + a_ff;
         h_in[1] = h_ff[1] + b_ff;
         h_in[2] = h_ff[2] + c_ff;
         h_in[3] = h_ff[3] + d_ff;
         h_in[4] = h_ff[4] + e_ff;
      end
      if (wr_byte) begin
         fill_in = fill_ff + 6'd1;
      end
      if (cmd.absorb) begin
         bit_cnt_in = bit_cnt_ff + 64'd8;
      end
      if (cmd.pad && (fill_ff == 6'd63)) begin
         len_ok_in = 1'b1;
      end else if (cmd.pad_first) begin
         len_ok_in = (fill_ff < 6'd56);
      end
      if (cmd.clear) begin
         for (int i = 0; i < 5; i++) begin
            h_in[i] = sha1s_pkg::H_INIT[i];
         end
         bit_cnt_in = '0;
         fill_in    = '0;
         len_ok_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            h_ff[i] <= sha1s_pkg::H_INIT[i];
         end
         bit_cnt_ff <= '0;
         fill_ff    <= '0;
         len_ok_ff  <= 1'b0;
      end else begin
         h_ff       <= h_in;
         bit_cnt_ff <= bit_cnt_in;
         fill_ff    <= fill_in;
         len_ok_ff  <= len_ok_in;
      end
   end

   // byte packing, schedule window and working variables
   always_ff @(posedge clock) begin
      if (wr_byte) begin
         word_ff <= {word_ff[15:0], byte_val};
         if (fill_ff[1:0] == 2'd3) begin
            for (int i = 0; i < 15; i++) begin
               sched_ff[i] <= sched_ff[i + 1];
            end
            sched_ff[15] <= {word_ff, byte_val};
         end
         if (fill_ff == 6'd63) begin
            a_ff <= h_ff[0];
            b_ff <= h_ff[1];
            c_ff <= h_ff[2];
            d_ff <= h_ff[3];
            e_ff <= h_ff[4];
         end
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i + 1];
         end
         sched_ff[15] <= w_new;
         a_ff <= t_val;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   // digest word select
   always_comb begin
      case (cmd.out_index)
         3'd0:    digest_word = h_ff[0];
         3'd1:    digest_word = h_ff[1];
         3'd2:    digest_word = h_ff[2];
         3'd3:    digest_word = h_ff[3];
         default: digest_word = h_ff[4];
      endcase
   end

endmodule

FILE: rtl/core/sha1_stream_hash_top.sv
`timescale 1ns / 1ps

// SHA-1 hasher fed one message byte per transaction. kind 0 is a data byte,
// kind 1 a data byte that ends the message, kind 2 ends the message with no
// byte (empty messages allowed); kind 3 is accepted and ignored. Every 64th
// byte starts the compression, which runs one round per cycle on a single
// round unit: 80 rounds, then a fold into the hash words, during which no
// request is taken. At the end of a message the padding is generated one
// byte per cycle through the same byte path, pausing while a full block is
// compressed (up to 64 bytes for one block, up to 72 when the length spills
// into a second block); each padded block is compressed in turn. Then the
// five digest words appear on the response channel, index 0 first, and the
// hasher returns to its initial state. Requests are taken only while no
// message end or compression is in progress.
module sha1_stream_hash_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha1s_pkg::cmd_type    cmd;
   sha1s_pkg::status_type status;

   sha1s_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word_index (rsp_word_index),
      .rsp_last_word  (rsp_last_word),
      .status         (status),
      .cmd            (cmd)
   );

   sha1s_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_data_byte (req_data_byte),
      .status        (status),
      .digest_word   (rsp_digest_word)
   );

`ifndef ASSERT_OFF
   // requests and digest output never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response channels active together");

   // after the last digest word the hasher is ready for a new message
   a_ready_after_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=> req_ready)
      else $error("not ready after final digest word");

   // only one datapath operation per cycle
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.absorb, cmd.pad, cmd.round, cmd.fold, cmd.clear}))
      else $error("conflicting datapath commands");
`endif

endmodule
